FILE: hdl/array_list_engine_unit_macros.svh
// assertion macros for the array list engine
// used by modules that check their own sequencing; relies on clk_i and rst_ni in scope
`ifndef ARRAY_LIST_ENGINE_UNIT_MACROS_SVH
`define ARRAY_LIST_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, off during reset
`define ALE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define ALE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ale_pkg.sv
// shared types and constants of the array list engine
// no dependencies
package ale_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 7;
  localparam int unsigned IDX_OUT_W = 7;
  localparam int unsigned CNT_OUT_W = 8;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_READ   = 2'd3
  } ale_cmd_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BADPOS   = 2'd2,
    ST_NOTFOUND = 2'd3
  } ale_status_e;

  typedef struct packed {
    ale_status_e               status;
    logic signed [DATA_W-1:0]  read_value;
    logic [IDX_OUT_W-1:0]      found_index;
    logic [CNT_OUT_W-1:0]      count;
  } ale_result_t;

endpackage

FILE: hdl/ale_if.sv
// command and response channel interfaces of the array list engine
// depends on ale_pkg for field widths
interface ale_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        command;
  logic signed [ale_pkg::DATA_W-1:0] value;
  logic [ale_pkg::POS_W-1:0]         position;

  modport source (output valid, command, value, position, input ready);
  modport sink   (input valid, command, value, position, output ready);
endinterface

interface ale_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [1:0]                           status;
  logic signed [ale_pkg::DATA_W-1:0]    read_value;
  logic [ale_pkg::IDX_OUT_W-1:0]        found_index;
  logic [ale_pkg::CNT_OUT_W-1:0]        count;

  modport source (output valid, status, read_value, found_index, count, input ready);
  modport sink   (input valid, status, read_value, found_index, count, output ready);
endinterface

FILE: hdl/ale_mem.sv
// element store: one write port, one read port with registered read data
// depends on ale_pkg for the data width
module ale_mem #(
  parameter int unsigned DEPTH = 128,
  parameter int unsigned AW    = 7
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [AW-1:0]                     waddr_i,
  input  logic signed [ale_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]                     raddr_i,
  output logic signed [ale_pkg::DATA_W-1:0] rdata_o
);
  import ale_pkg::*;

  logic signed [DATA_W-1:0] mem_q [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered: data follows in the cycle after the address
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/ale_ctrl.sv
// command sequencer: checks a command, walks the store one entry per cycle
// for shifts, searches and reads, and keeps the element count; uses ale_pkg
`include "array_list_engine_unit_macros.svh"

module ale_ctrl #(
  parameter int unsigned CAPACITY = 128,
  parameter int unsigned AW       = 7,
  parameter int unsigned CW       = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  ale_pkg::ale_cmd_e                 in_command_i,
  input  logic signed [ale_pkg::DATA_W-1:0] in_value_i,
  input  logic [ale_pkg::POS_W-1:0]         in_position_i,
  output logic                              res_valid_o,
  input  logic                              res_take_i,
  output ale_pkg::ale_result_t              res_o,
  output logic                              mem_we_o,
  output logic [AW-1:0]                     mem_waddr_o,
  output logic signed [ale_pkg::DATA_W-1:0] mem_wdata_o,
  output logic [AW-1:0]                     mem_raddr_o,
  input  logic signed [ale_pkg::DATA_W-1:0] mem_rdata_i
);
  import ale_pkg::*;

  // common width for position and count compares
  localparam int unsigned WW = ((CW > CNT_OUT_W) ? CW : CNT_OUT_W) + 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FIN,
    S_DONE
  } state_e;

  state_e                   state_q, state_d;
  ale_cmd_e                 op_q, op_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic [AW-1:0]            pos_q, pos_d;
  logic [AW-1:0]            src_q, src_d;
  logic [CW-1:0]            left_q, left_d;
  logic                     pend_q, pend_d;
  logic [AW-1:0]            pend_addr_q, pend_addr_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  ale_result_t              res_q, res_d;

  logic [WW-1:0] pos_w;
  logic [WW-1:0] cnt_w;
  logic [WW-1:0] cap_w;
  logic          accept;

  assign pos_w  = WW'(in_position_i);
  assign cnt_w  = WW'(cnt_q);
  assign cap_w  = WW'(CAPACITY);
  assign accept = in_valid_i && (state_q == S_IDLE);

  assign in_ready_o  = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;
  assign mem_raddr_o = src_q;

  // next state, store port control and result assembly
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    val_d       = val_q;
    pos_d       = pos_q;
    src_d       = src_q;
    left_d      = left_q;
    pend_d      = 1'b0;
    pend_addr_d = src_q;
    cnt_d       = cnt_q;
    res_d       = res_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = pend_addr_q;
    mem_wdata_o = mem_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d              = in_command_i;
          val_d             = in_value_i;
          pos_d             = AW'(pos_w);
          res_d.status      = ST_OK;
          res_d.read_value  = '0;
          res_d.found_index = '0;
          res_d.count       = CNT_OUT_W'(cnt_w);
          state_d           = S_RUN;
          case (in_command_i)
            CMD_INSERT: begin
              left_d = CW'(cnt_w - pos_w);
              src_d  = AW'(cnt_w - WW'(1));
              if (cnt_w >= cap_w) begin
                res_d.status = ST_FULL;
                state_d      = S_DONE;
              end else if (pos_w > cnt_w) begin
                res_d.status = ST_BADPOS;
                state_d      = S_DONE;
              end
            end
            CMD_DELETE: begin
              left_d = CW'(cnt_w - pos_w - WW'(1));
              src_d  = AW'(pos_w + WW'(1));
              if (pos_w >= cnt_w) begin
                res_d.status = ST_BADPOS;
                state_d      = S_DONE;
              end
            end
            CMD_FIND: begin
              left_d       = cnt_q;
              src_d        = '0;
              res_d.status = ST_NOTFOUND;
              if (cnt_q == '0) begin
                state_d = S_DONE;
              end
            end
            default: begin
              left_d = CW'(1);
              src_d  = AW'(pos_w);
              if (pos_w >= cnt_w) begin
                res_d.status = ST_BADPOS;
                state_d      = S_DONE;
              end
            end
          endcase
        end
      end

      S_RUN: begin
        // issue one read per cycle while entries remain
        if (left_q != '0) begin
          pend_d = 1'b1;
          left_d = left_q - CW'(1);
          src_d  = (op_q == CMD_INSERT) ? src_q - AW'(1) : src_q + AW'(1);
        end
        // consume the entry read in the previous cycle
        if (pend_q) begin
          case (op_q)
            CMD_INSERT: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pend_addr_q + AW'(1);
            end
            CMD_DELETE: begin
              mem_we_o    = 1'b1;
              mem_waddr_o = pend_addr_q - AW'(1);
            end
            CMD_FIND: begin
              if (mem_rdata_i == val_q) begin
                res_d.status      = ST_OK;
                res_d.found_index = IDX_OUT_W'(WW'(pend_addr_q));
                left_d            = '0;
                pend_d            = 1'b0;
              end
            end
            default: begin
              res_d.read_value = mem_rdata_i;
            end
          endcase
        end
        if ((left_q == '0) && !pend_q) begin
          state_d = S_FIN;
        end
      end

      S_FIN: begin
        // place the new value and settle the count
        case (op_q)
          CMD_INSERT: begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pos_q;
            mem_wdata_o = val_q;
            cnt_d       = cnt_q + CW'(1);
          end
          CMD_DELETE: begin
            cnt_d = cnt_q - CW'(1);
          end
          default: begin
            cnt_d = cnt_q;
          end
        endcase
        res_d.count = CNT_OUT_W'(WW'(cnt_d));
        state_d     = S_DONE;
      end

      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      op_q        <= CMD_INSERT;
      val_q       <= '0;
      pos_q       <= '0;
      src_q       <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      cnt_q       <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      val_q       <= val_d;
      pos_q       <= pos_d;
      src_q       <= src_d;
      left_q      <= left_d;
      pend_q      <= pend_d;
      pend_addr_q <= pend_addr_d;
      cnt_q       <= cnt_d;
      res_q       <= res_d;
    end
  end

  // sequencing checks
  `ALE_ASSERT_IMP(a_cnt_cap, 1'b1, cnt_q <= CW'(CAPACITY), "element count above capacity")
  `ALE_ASSERT_NXT(a_cnt_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q == $past(cnt_q) - CW'(1)), "count moved by more than one")
  `ALE_ASSERT_NXT(a_busy_after_beat, accept, !in_ready_o, "ready right after an accepted beat")
  `ALE_ASSERT_IMP(a_we_phase, mem_we_o, (state_q == S_RUN) || (state_q == S_FIN), "store written outside a command")

endmodule

FILE: hdl/array_list_engine_unit.sv
// array list engine: one command in, one result out; each command walks store entries
// one per cycle through the single read port (count - position for insert, one less for
// delete, hit index + 1 or count for find, one for read), none for a rejected command or a
// find on an empty list; a new command is taken only once the last result has moved into
// the output register, and it can be taken while that result still waits there
// reset (async, active low) empties the list; store contents are not cleared
module array_list_engine_unit #(
  parameter int unsigned CAPACITY = 128
) (
  input logic       clk_i,
  input logic       rst_ni,
  ale_cmd_if.sink   cmd_i,
  ale_rsp_if.source rsp_o
);
  import ale_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic                     res_valid;
  logic                     res_take;
  ale_result_t              res;
  logic                     mem_we;
  logic [AW-1:0]            mem_waddr;
  logic signed [DATA_W-1:0] mem_wdata;
  logic [AW-1:0]            mem_raddr;
  logic signed [DATA_W-1:0] mem_rdata;
  logic                     out_valid_q;
  ale_result_t              out_q;

  ale_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (cmd_i.valid),
    .in_ready_o    (cmd_i.ready),
    .in_command_i  (ale_cmd_e'(cmd_i.command)),
    .in_value_i    (cmd_i.value),
    .in_position_i (cmd_i.position),
    .res_valid_o   (res_valid),
    .res_take_i    (res_take),
    .res_o         (res),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  ale_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // output register holds a result beat until the sink takes it
  assign res_take = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_take) begin
        out_valid_q <= res_valid;
        if (res_valid) begin
          out_q <= res;
        end
      end
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_q.status;
  assign rsp_o.read_value  = out_q.read_value;
  assign rsp_o.found_index = out_q.found_index;
  assign rsp_o.count       = out_q.count;

endmodule
